FILE: src/pqme_pkg.sv
// ----------------------------------------------------------------------------
// pqme_pkg
// Shared types and constants of the max-extract priority queue.
// ----------------------------------------------------------------------------
package pqme_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned CfgW         = 5;
  localparam int unsigned OccW         = 5;
  localparam logic [CfgW-1:0] CapReset = CfgW'(5);

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] item_value;
    logic signed [31:0] item_priority;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic signed [31:0] removed_value;
    logic signed [31:0] removed_priority;
    logic [OccW-1:0]    occupancy;
    logic               is_full;
    logic               is_empty;
  } out_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [31:0] prio;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic scan;
    logic seed;
    logic occupied;
  } cell_ctrl_t;

endpackage

FILE: src/pqme_cell.sv
// ----------------------------------------------------------------------------
// pqme_cell
// One queue slot: holds an entry, shifts from its upper neighbor and passes
// the running maximum of the search wave on to the next slot.
// ----------------------------------------------------------------------------
module pqme_cell #(
  parameter int unsigned IdxW  = 4,
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  pqme_pkg::cell_ctrl_t ctrl_i,
  input  pqme_pkg::entry_t    item_i,
  input  pqme_pkg::entry_t    next_i,
  input  pqme_pkg::entry_t    carry_i,
  input  logic [IdxW-1:0]     carry_idx_i,
  output pqme_pkg::entry_t    entry_o,
  output pqme_pkg::entry_t    carry_o,
  output logic [IdxW-1:0]     carry_idx_o
);

  pqme_pkg::entry_t ent_q;
  pqme_pkg::entry_t carry_q;
  logic [IdxW-1:0]  carry_idx_q;
  logic             take_own;

  assign take_own = ctrl_i.seed ||
                    (ctrl_i.occupied && (ent_q.prio > carry_i.prio));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      ent_q <= item_i;
    end else if (ctrl_i.shift) begin
      ent_q <= next_i;
    end
    if (ctrl_i.scan) begin
      if (take_own) begin
        carry_q     <= ent_q;
        carry_idx_q <= IdxW'(Index);
      end else begin
        carry_q     <= carry_i;
        carry_idx_q <= carry_idx_i;
      end
    end
  end

  assign entry_o     = ent_q;
  assign carry_o     = carry_q;
  assign carry_idx_o = carry_idx_q;

endmodule

FILE: src/priority_queue_max_extract_core.sv
// ----------------------------------------------------------------------------
// priority_queue_max_extract_core
// Bounded priority queue over a chain of slot cells.
//
// Input channel (in_valid_i/in_ready_o, in_item_i): an insert appends a
// pair; a removal extracts the oldest entry of greatest priority. Output
// channel (out_valid_o/out_ready_i, out_item_o) returns one result per item.
// Configuration: cfg_we_i writes the capacity from cfg_wdata_i.
//
// Sequence: an insert, or a removal from an empty queue, goes from
// acceptance straight to the result stage (StDone), and the next item is
// taken once that result has moved into the output register. A removal
// sends a search wave through all DEPTH cells, one cell a cycle, then
// shifts the slots above the winner down in the StShift state.
// Reset empties the queue and sets the capacity to 5; slot contents are
// not cleared. The output register holds a result while the receiver
// stalls; the next item is still accepted, and its result waits inside
// until the output register frees.
// ----------------------------------------------------------------------------
module priority_queue_max_extract_core #(
  parameter int unsigned DEPTH = pqme_pkg::DefaultDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pqme_pkg::CfgW-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pqme_pkg::in_t              in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pqme_pkg::out_t             out_item_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CapW = (CntW > pqme_pkg::CfgW) ? CntW : pqme_pkg::CfgW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StShift,
    StDone
  } state_e;

  state_e                    state_q;
  logic [IdxW-1:0]           pos_q;
  logic [CntW-1:0]           count_q, count_d;
  logic [pqme_pkg::CfgW-1:0] cap_q;
  pqme_pkg::out_t            res_q, res_d;
  pqme_pkg::out_t            out_q;
  logic                      out_valid_q;

  pqme_pkg::entry_t     ent   [DEPTH];
  pqme_pkg::entry_t     carry [DEPTH];
  logic [IdxW-1:0]      cidx  [DEPTH];
  pqme_pkg::cell_ctrl_t ctrl  [DEPTH];

  logic [CapW-1:0]  eff_cap, cap_ext, count_ext;
  logic             in_fire, is_ins, ins_ok, load_out, load_res;
  logic [IdxW-1:0]  best_idx;
  pqme_pkg::entry_t best;
  pqme_pkg::entry_t item;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;
  assign is_ins     = (in_item_i.operation == pqme_pkg::OpInsert);
  assign item.value = in_item_i.item_value;
  assign item.prio  = in_item_i.item_priority;

  assign cap_ext   = CapW'(cap_q);
  assign count_ext = CapW'(count_q);

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CapW'(1);
    end else if (cap_ext > CapW'(DEPTH)) begin
      eff_cap = CapW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign ins_ok   = (count_ext < eff_cap);
  assign best     = carry[DEPTH-1];
  assign best_idx = cidx[DEPTH-1];

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].load     = in_fire && is_ins && ins_ok && (count_q == CntW'(i));
      ctrl[i].scan     = (state_q == StScan) && (pos_q == IdxW'(i));
      ctrl[i].seed     = (i == 0);
      ctrl[i].occupied = (CntW'(i) < count_q);
      ctrl[i].shift    = (state_q == StShift) && (IdxW'(i) >= best_idx) &&
                         (CntW'(i + 1) < count_q);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    pqme_pkg::entry_t next_ent, carry_in;
    logic [IdxW-1:0]  carry_idx_in;
    if (g < DEPTH - 1) begin : g_next
      assign next_ent = ent[g+1];
    end else begin : g_top
      assign next_ent = ent[g];
    end
    if (g > 0) begin : g_chain
      assign carry_in     = carry[g-1];
      assign carry_idx_in = cidx[g-1];
    end else begin : g_head
      assign carry_in     = ent[0];
      assign carry_idx_in = '0;
    end
    pqme_cell #(
      .IdxW (IdxW),
      .Index(g)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl[g]),
      .item_i     (item),
      .next_i     (next_ent),
      .carry_i    (carry_in),
      .carry_idx_i(carry_idx_in),
      .entry_o    (ent[g]),
      .carry_o    (carry[g]),
      .carry_idx_o(cidx[g])
    );
  end

  always_comb begin
    count_d                = count_q;
    res_d                  = res_q;
    res_d.status           = pqme_pkg::StOk;
    res_d.removed_value    = '0;
    res_d.removed_priority = '0;
    load_res               = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (is_ins) begin
            load_res = 1'b1;
            if (ins_ok) begin
              count_d = count_q + 1'b1;
            end else begin
              res_d.status = pqme_pkg::StFull;
            end
          end else if (count_q == '0) begin
            load_res     = 1'b1;
            res_d.status = pqme_pkg::StEmpty;
          end
        end
      end
      StShift: begin
        load_res               = 1'b1;
        count_d                = count_q - 1'b1;
        res_d.removed_value    = best.value;
        res_d.removed_priority = best.prio;
      end
      default: begin
        load_res = 1'b0;
      end
    endcase
    res_d.occupancy = pqme_pkg::OccW'(count_d);
    res_d.is_full   = (CapW'(count_d) >= eff_cap);
    res_d.is_empty  = (count_d == '0);
  end

  assign load_out = (state_q == StDone) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      pos_q       <= '0;
      count_q     <= '0;
      cap_q       <= pqme_pkg::CapReset;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (in_fire) begin
            pos_q <= '0;
            if (is_ins || (count_q == '0)) begin
              state_q <= StDone;
            end else begin
              state_q <= StScan;
            end
          end
        end
        StScan: begin
          pos_q <= pos_q + 1'b1;
          if (pos_q == IdxW'(DEPTH - 1)) begin
            state_q <= StShift;
          end
        end
        StShift: begin
          state_q <= StDone;
        end
        StDone: begin
          if (load_out) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_res) begin
      res_q <= res_d;
    end
    if (load_out) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: src/pqme_checker.sv
// ----------------------------------------------------------------------------
// pqme_checker
// Port-level checks of the max-extract priority queue, bound to the core.
// ----------------------------------------------------------------------------
module pqme_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_ready_i,
  input pqme_pkg::out_t            out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item dropped or changed while stalled");

  a_full_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == pqme_pkg::StFull) |->
      out_item_o.is_full && (out_item_o.removed_value == '0) &&
      (out_item_o.removed_priority == '0))
    else $error("refused insert reports inconsistent fields");

  a_empty_refusal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == pqme_pkg::StEmpty) |->
      out_item_o.is_empty && (out_item_o.occupancy == '0) &&
      (out_item_o.removed_value == '0) && (out_item_o.removed_priority == '0))
    else $error("refused removal reports inconsistent fields");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.is_empty |-> (out_item_o.occupancy == '0))
    else $error("empty flag disagrees with occupancy");

endmodule

bind priority_queue_max_extract_core pqme_checker u_pqme_checker (.*);
